/* hw/rtl/ocpi_pkg.sv */
package ocpi_pkg;

  // Port widths fixed by the interface.
  localparam int DATA_W   = 16;
  localparam int RB_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 7;
  localparam int LEN_W    = 12;
  localparam int ROW_W    = 3;
  localparam int NUM_ROWS = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PREFIX   = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [RB_W-1:0] RB_RESET     = 7'd6;
  localparam logic            NORMAL_RESET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the pushed sample and advance the load count
    logic read;        // read the next emitted sample and advance the emit count
    logic start_emit;  // symbol complete, set up the emit pointers
    logic end_emit;    // final sample read, return to loading
    logic advance;     // move the pending result into the output register
    logic s1_pull_ok;  // pending result carries sample data
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_full;  // the next stored sample completes the symbol
    logic emit_end;   // the next read sample is the final one
  } status_t;

  // Row selection from the resource block count.
  function automatic logic [ROW_W-1:0] rb_row(input logic [RB_W-1:0] rb);
    logic [ROW_W-1:0] r;
    if (rb < 7'd12) begin
      r = 3'd0;
    end else if (rb < 7'd25) begin
      r = 3'd1;
    end else if (rb < 7'd50) begin
      r = 3'd2;
    end else if (rb < 7'd75) begin
      r = 3'd3;
    end else if (rb < 7'd110) begin
      r = 3'd4;
    end else begin
      r = 3'd5;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] row_fft(input logic [ROW_W-1:0] r);
    logic [LEN_W-1:0] v;
    case (r)
      3'd0:    v = 12'd128;
      3'd1:    v = 12'd256;
      3'd2:    v = 12'd512;
      3'd3:    v = 12'd1024;
      3'd4:    v = 12'd1536;
      default: v = 12'd2048;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] row_long(input logic [ROW_W-1:0] r);
    logic [LEN_W-1:0] v;
    case (r)
      3'd0:    v = 12'd10;
      3'd1:    v = 12'd20;
      3'd2:    v = 12'd40;
      3'd3:    v = 12'd80;
      3'd4:    v = 12'd120;
      default: v = 12'd160;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] row_short(input logic [ROW_W-1:0] r);
    logic [LEN_W-1:0] v;
    case (r)
      3'd0:    v = 12'd9;
      3'd1:    v = 12'd18;
      3'd2:    v = 12'd36;
      3'd3:    v = 12'd72;
      3'd4:    v = 12'd108;
      default: v = 12'd144;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] row_ext(input logic [ROW_W-1:0] r);
    logic [LEN_W-1:0] v;
    case (r)
      3'd0:    v = 12'd32;
      3'd1:    v = 12'd64;
      3'd2:    v = 12'd128;
      3'd3:    v = 12'd256;
      3'd4:    v = 12'd384;
      default: v = 12'd512;
    endcase
    return v;
  endfunction

  // Largest row whose symbol size fits the store; evaluated at elaboration.
  function automatic logic [ROW_W-1:0] max_row(input int max_points);
    logic [ROW_W-1:0] best;
    best = 3'd0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (int'(row_fft(ROW_W'(r))) <= max_points) begin
        best = ROW_W'(r);
      end
    end
    return best;
  endfunction

endpackage

/* hw/rtl/ocpi_ram.sv */
module ocpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ocpi_ctrl.sv */
module ocpi_ctrl
  import ocpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    operation,
  output logic    res_valid,
  input  logic    res_stall,
  output logic    push_accepted,
  output logic    out_valid,
  output logic    out_last,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [1:0] {
    MODE_LOAD = 2'b01,
    MODE_EMIT = 2'b10
  } mode_t;

  mode_t mode, mode_next;
  logic  s1_valid, s1_push_ok, s1_pull_ok, s1_last;
  logic  accept, push_ok, pull_ok, advance;

  // A new beat is refused only when both the pending stage and the output are held.
  assign in_stall = s1_valid && res_valid && res_stall;
  assign accept   = in_valid && !in_stall;
  assign push_ok  = accept && !operation && (mode == MODE_LOAD);
  assign pull_ok  = accept && operation && (mode == MODE_EMIT);
  assign advance  = s1_valid && (!res_valid || !res_stall);

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_LOAD: begin
        if (push_ok && status.load_full) begin
          mode_next = MODE_EMIT;
        end
      end
      MODE_EMIT: begin
        if (pull_ok && status.emit_end) begin
          mode_next = MODE_LOAD;
        end
      end
      default: mode_next = MODE_LOAD;
    endcase
  end

  always_comb begin
    cmd.store      = push_ok;
    cmd.read       = pull_ok;
    cmd.start_emit = push_ok && status.load_full;
    cmd.end_emit   = pull_ok && status.emit_end;
    cmd.advance    = advance;
    cmd.s1_pull_ok = s1_pull_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_LOAD;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      mode <= mode_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_push_ok <= push_ok;
      s1_pull_ok <= pull_ok;
      s1_last    <= pull_ok && status.emit_end;
    end
    if (advance) begin
      push_accepted <= s1_push_ok;
      out_valid     <= s1_pull_ok;
      out_last      <= s1_last;
    end
  end

endmodule

/* hw/rtl/ocpi_dp.sv */
module ocpi_dp
  import ocpi_pkg::*;
#(
  parameter int MAX_FFT_POINTS = 2048,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [DATA_W-1:0] in_real,
  input  logic signed [DATA_W-1:0] in_imag,
  input  logic                     first_of_slot,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic signed [DATA_W-1:0] out_real,
  output logic signed [DATA_W-1:0] out_imag
);

  localparam int KEEP_W = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
  localparam int WORD_W = 2 * KEEP_W;
  localparam int AW     = $clog2(MAX_FFT_POINTS);
  localparam int CNT_W  = $clog2(2 * MAX_FFT_POINTS);
  localparam logic [ROW_W-1:0] ROW_MAX = max_row(MAX_FFT_POINTS);

  logic [RB_W-1:0]   resource_blocks;
  logic              normal_prefix;
  logic [CNT_W-1:0]  load_count, emit_count;
  logic [CNT_W-1:0]  sym_len, pfx_len, total_len;
  logic [AW-1:0]     rd_ptr;
  logic [ROW_W-1:0]  row_sel, row_eff;
  logic [LEN_W-1:0]  pfx_sel;
  logic [CNT_W-1:0]  load_inc, emit_inc;
  logic [WORD_W-1:0] wr_word, rd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_blocks <= RB_RESET;
      normal_prefix   <= NORMAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RESOURCE_BLOCKS: resource_blocks <= cfg_data[RB_W-1:0];
        REG_NORMAL_PREFIX:   normal_prefix   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry for the symbol that starts with the current push.
  assign row_sel = rb_row(resource_blocks);
  assign row_eff = (row_sel > ROW_MAX) ? ROW_MAX : row_sel;
  always_comb begin
    if (!normal_prefix) begin
      pfx_sel = row_ext(row_eff);
    end else if (first_of_slot) begin
      pfx_sel = row_long(row_eff);
    end else begin
      pfx_sel = row_short(row_eff);
    end
  end

  assign load_inc = load_count + 1'b1;
  assign emit_inc = emit_count + 1'b1;
  assign status.load_full = (load_inc == sym_len);
  assign status.emit_end  = (emit_inc == total_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      emit_count <= '0;
      sym_len    <= '0;
      pfx_len    <= '0;
      total_len  <= '0;
    end else begin
      if (cmd.store) begin
        load_count <= load_inc;
        if (load_count == '0) begin
          sym_len   <= CNT_W'(row_fft(row_eff));
          pfx_len   <= CNT_W'(pfx_sel);
          total_len <= CNT_W'(row_fft(row_eff) + pfx_sel);
        end
      end
      if (cmd.start_emit) begin
        emit_count <= '0;
      end else if (cmd.end_emit) begin
        emit_count <= '0;
        load_count <= '0;
      end else if (cmd.read) begin
        emit_count <= emit_inc;
      end
    end
  end

  // Read pointer: the prefix starts at the tail of the symbol, then the body from zero.
  always_ff @(posedge clk) begin
    if (cmd.start_emit) begin
      rd_ptr <= AW'(sym_len - pfx_len);
    end else if (cmd.read) begin
      if (emit_inc == pfx_len) begin
        rd_ptr <= '0;
      end else begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign wr_word = {in_imag[KEEP_W-1:0], in_real[KEEP_W-1:0]};

  ocpi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_FFT_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (load_count[AW-1:0]),
    .wr_data (wr_word),
    .rd_en   (cmd.read),
    .rd_addr (rd_ptr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      if (cmd.s1_pull_ok) begin
        out_real <= DATA_W'(rd_word[KEEP_W-1:0]);
        out_imag <= DATA_W'(rd_word[WORD_W-1:KEEP_W]);
      end else begin
        out_real <= '0;
        out_imag <= '0;
      end
    end
  end

endmodule

/* hw/rtl/ofdm_cyclic_prefix_inserter_top.sv */
// Each accepted beat passes through the pending stage and then the output
// register. Throughput: one beat per cycle, push or pull, while in_stall is low;
// the registered read of the symbol store sets the two-stage pipeline behind it.
// Reset (rst, synchronous, active high): loading mode, counts zero, no beat
// pending, resource_blocks 6 and normal_prefix 1. The symbol store is not cleared.
module ofdm_cyclic_prefix_inserter_top
  import ocpi_pkg::*;
#(
  parameter int MAX_FFT_POINTS = 2048,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic signed [DATA_W-1:0] in_real,
  input  logic signed [DATA_W-1:0] in_imag,
  input  logic                     first_of_slot,
  // Result channel.
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic                     push_accepted,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_real,
  output logic signed [DATA_W-1:0] out_imag,
  output logic                     out_last
);

  // Every accepted beat produces exactly one result beat. A push stores one
  // sample while loading and is refused while a prefixed symbol is being
  // emitted. Once the symbol is full, pulls return the last prefix-length
  // samples followed by the whole symbol, with out_last on the final one.
  //
  // The controller keeps the load/emit mode and the handshake pipeline: one
  // pending stage waiting on the store read, then the output register. A
  // new beat is accepted whenever the pending stage is empty or can drain, so
  // a stalled output holds back the input only once the pending stage is full.
  //
  // The datapath holds the configuration registers, the symbol geometry
  // latched on a symbol's first push, the load and emit counters, the read
  // pointer and the symbol store itself.

  cmd_t    cmd;
  status_t status;

  ocpi_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .push_accepted (push_accepted),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .cmd           (cmd),
    .status        (status)
  );

  ocpi_dp #(
    .MAX_FFT_POINTS (MAX_FFT_POINTS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_real       (in_real),
    .in_imag       (in_imag),
    .first_of_slot (first_of_slot),
    .cmd           (cmd),
    .status        (status),
    .out_real      (out_real),
    .out_imag      (out_imag)
  );

endmodule

/* verif/ofdm_cyclic_prefix_inserter_top_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the cyclic prefix inserter. A behavioural copy of the
// inserter runs beside the block: every input beat that the block accepts is
// pushed through it, and the beat that it should produce is queued. Every
// result beat that leaves the block is compared field by field with the oldest
// queued beat.
module ofdm_cyclic_prefix_inserter_top_tb;
  import ocpi_pkg::*;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } sample_op_e;

  typedef struct packed {
    logic              accepted;
    logic              valid;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              last;
  } prefixed_beat_t;

  localparam int unsigned STORE_DEPTH   = 2048;
  localparam int unsigned MAX_GAP       = 16;
  localparam int unsigned HOLD_BEATS    = 40;

  // Ports of the block.
  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     operation;
  logic signed [DATA_W-1:0] in_real;
  logic signed [DATA_W-1:0] in_imag;
  logic                     first_of_slot;
  logic                     res_valid;
  logic                     res_stall;
  logic                     push_accepted;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_real;
  logic signed [DATA_W-1:0] out_imag;
  logic                     out_last;

  // The bench's own view of the inserter: held samples, counts and settings.
  logic [2*DATA_W-1:0] held_samples [0:STORE_DEPTH-1];
  int unsigned         samples_in;
  int unsigned         samples_out;
  bit                  in_emission;
  int unsigned         sym_points;
  int unsigned         cp_points;
  logic [RB_W-1:0]     rb_setting;
  bit                  normal_setting;

  // Beats that the block still owes us, oldest first.
  prefixed_beat_t pending_beats [$];

  // Idling control shared between the stimulus and the result sink.
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned hold_cycles;

  // Tallies for the closing summary.
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_symbols;
  int unsigned n_stored;
  int unsigned n_emitted;
  int unsigned n_refused;
  int unsigned n_idle_pulls;

  ofdm_cyclic_prefix_inserter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .in_real       (in_real),
    .in_imag       (in_imag),
    .first_of_slot (first_of_slot),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .push_accepted (push_accepted),
    .out_valid     (out_valid),
    .out_real      (out_real),
    .out_imag      (out_imag),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result beat of one accepted input beat and advances the
  // bench's copy of the inserter. The symbol size and the prefix length are
  // fixed by the settings in force when the first sample of a symbol arrives;
  // every prefix length is a fixed fraction of the FFT size.
  function automatic prefixed_beat_t predict_prefixed_beat(input sample_op_e op,
                                                           input logic [DATA_W-1:0] re,
                                                           input logic [DATA_W-1:0] im,
                                                           input bit long_cp);
    prefixed_beat_t  beat;
    logic [2*DATA_W-1:0] word;
    int unsigned     addr;
    beat = '0;
    if (op == OP_PUSH) begin
      // A push during emission is simply refused.
      if (in_emission) begin
        n_refused++;
        return beat;
      end
      if (samples_in == 0) begin
        if (rb_setting < 12) sym_points = 128;
        else if (rb_setting < 25) sym_points = 256;
        else if (rb_setting < 50) sym_points = 512;
        else if (rb_setting < 75) sym_points = 1024;
        else if (rb_setting < 110) sym_points = 1536;
        else sym_points = 2048;
        if (!normal_setting) cp_points = sym_points / 4;
        else if (long_cp) cp_points = sym_points * 10 / 128;
        else cp_points = sym_points * 9 / 128;
      end
      held_samples[samples_in] = {im, re};
      samples_in++;
      if (samples_in >= sym_points) begin
        in_emission = 1'b1;
        samples_out = 0;
      end
      beat.accepted = 1'b1;
      n_stored++;
      return beat;
    end
    // A pull while the symbol is still loading returns an empty beat.
    if (!in_emission) begin
      n_idle_pulls++;
      return beat;
    end
    // The prefix repeats the tail of the symbol, then the whole symbol follows.
    if (samples_out < cp_points) addr = sym_points - cp_points + samples_out;
    else addr = samples_out - cp_points;
    word = held_samples[addr];
    beat.valid = 1'b1;
    beat.re    = word[DATA_W-1:0];
    beat.im    = word[2*DATA_W-1:DATA_W];
    samples_out++;
    if (samples_out >= sym_points + cp_points) begin
      beat.last   = 1'b1;
      in_emission = 1'b0;
      samples_out = 0;
      samples_in  = 0;
      n_symbols++;
    end
    n_emitted++;
    return beat;
  endfunction

  task automatic note_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s is %h, expected %h (beat %0d)", name, got, want, n_checked));
    end
  endtask

  // Offers one beat after a random gap and returns once the block has taken it.
  // Valid is only lowered when a gap follows, so a back-to-back beat never sees
  // valid fall and rise again at the same edge.
  task automatic send_beat(input sample_op_e op, input logic [DATA_W-1:0] re,
                           input logic [DATA_W-1:0] im, input bit flag);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    in_real       <= re;
    in_imag       <= im;
    first_of_slot <= flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_beats.push_back(predict_prefixed_beat(op, re, im, flag));
  endtask

  // Lowers valid and waits until every owed beat has come back, plus some margin.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_RESOURCE_BLOCKS) rb_setting = value[RB_W-1:0];
    else normal_setting = value[0];
  endtask

  task automatic set_config(input logic [RB_W-1:0] rb, input bit normal);
    drain();
    write_reg(REG_RESOURCE_BLOCKS, CFG_W'(rb));
    write_reg(REG_NORMAL_PREFIX, CFG_W'(normal));
  endtask

  // Pushes random samples until the symbol is complete. The slot flag given
  // here only counts on the first sample; later samples carry random flags.
  // Stray pulls are sprinkled in at the given percentage.
  task automatic load_symbol(input bit long_cp, input int unsigned noise_pct);
    do begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(OP_PULL, DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(0, 1)));
      end
      send_beat(OP_PUSH, DATA_W'($urandom), DATA_W'($urandom),
                (samples_in == 0) ? long_cp : 1'($urandom_range(0, 1)));
    end while (!in_emission);
  endtask

  // Pulls until the final beat of the prefixed symbol, with stray pushes.
  task automatic emit_symbol(input int unsigned noise_pct);
    do begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(OP_PUSH, DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(0, 1)));
      end
      send_beat(OP_PULL, DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(0, 1)));
    end while (in_emission);
  endtask

  task automatic run_symbol(input bit long_cp, input int unsigned noise_pct);
    load_symbol(long_cp, noise_pct);
    emit_symbol(noise_pct);
  endtask

  // Straight after reset nothing is loaded, so pulls must come back empty
  // whatever the sample and flag fields hold.
  task automatic check_idle_pulls;
    send_beat(OP_PULL, 16'h8000, 16'h7fff, 1'b1);
    send_beat(OP_PULL, 16'hffff, 16'h0000, 1'b0);
    send_beat(OP_PULL, 16'h5555, 16'haaaa, 1'b1);
  endtask

  // One symbol at the reset settings (smallest size, long prefix) that starts
  // with the extreme sample values, a push refused during emission, and a
  // pull once the symbol has gone, which must find the block loading again.
  task automatic check_extreme_samples;
    send_beat(OP_PUSH, 16'h8000, 16'h7fff, 1'b1);
    send_beat(OP_PUSH, 16'h7fff, 16'h8000, 1'b0);
    send_beat(OP_PUSH, 16'h0000, 16'hffff, 1'b1);
    send_beat(OP_PUSH, 16'hffff, 16'h0000, 1'b0);
    send_beat(OP_PUSH, 16'h5555, 16'haaaa, 1'b1);
    send_beat(OP_PUSH, 16'haaaa, 16'h5555, 1'b0);
    load_symbol(1'b1, 0);
    send_beat(OP_PUSH, 16'h7fff, 16'h7fff, 1'b1);
    emit_symbol(10);
    send_beat(OP_PULL, 16'hffff, 16'hffff, 1'b1);
  endtask

  // The result side holds off for a long stretch while the sender keeps
  // offering pushes back to back, so the block fills up and stalls its input.
  task automatic check_backpressure;
    tx_quiet    = 1'b1;
    hold_cycles = 400;
    repeat (HOLD_BEATS) begin
      send_beat(OP_PUSH, DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Settings changed part way through loading must only apply to the next
  // symbol: the first one keeps the short prefix, the second takes the
  // extended prefix. The prefix register is written with stray upper bits,
  // which the block must ignore.
  task automatic check_settings_latch;
    set_config(7'd6, 1'b1);
    send_beat(OP_PUSH, DATA_W'($urandom), DATA_W'($urandom), 1'b0);
    drain();
    write_reg(REG_RESOURCE_BLOCKS, CFG_W'(7'd11));
    write_reg(REG_NORMAL_PREFIX, CFG_W'(7'h7e));
    run_symbol(1'b1, 10);
    run_symbol(1'b1, 2);
  endtask

  // Result sink: waits a random number of cycles before each beat, or for a
  // long requested hold, then takes the next beat.
  initial begin : result_sink
    int unsigned wait_cycles;
    res_stall <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
        wait_cycles = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (res_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Every result beat taken by the sink is matched against the oldest owed beat.
  always @(posedge clk) begin
    prefixed_beat_t want;
    if (!rst && res_valid === 1'b1 && !res_stall) begin
      n_checked++;
      if (pending_beats.size() == 0) begin
        note_mismatch("result beat arrived with nothing owed");
      end else begin
        want = pending_beats.pop_front();
        compare_field("push_accepted", DATA_W'(push_accepted), DATA_W'(want.accepted));
        compare_field("out_valid", DATA_W'(out_valid), DATA_W'(want.valid));
        compare_field("out_real", out_real, want.re);
        compare_field("out_imag", out_imag, want.im);
        compare_field("out_last", DATA_W'(out_last), DATA_W'(want.last));
      end
    end
  end

  // The slowest correct run stays well under a tenth of this.
  initial begin : watchdog
    #50_000_000;
    $display("Run timed out with %0d beats still owed.", pending_beats.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : test_sequence
    in_valid       <= 1'b0;
    operation      <= OP_PUSH;
    in_real        <= '0;
    in_imag        <= '0;
    first_of_slot  <= 1'b0;
    cfg_write      <= 1'b0;
    cfg_index      <= REG_RESOURCE_BLOCKS;
    cfg_data       <= '0;
    rst            <= 1'b1;
    samples_in     = 0;
    samples_out    = 0;
    in_emission    = 1'b0;
    sym_points     = 0;
    cp_points      = 0;
    rb_setting     = RB_RESET;
    normal_setting = NORMAL_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_idle_pulls();
    check_extreme_samples();
    check_settings_latch();
    check_backpressure();

    drain();
    repeat (8) @(posedge clk);
    if (pending_beats.size() != 0) begin
      note_mismatch($sformatf("%0d result beats never arrived", pending_beats.size()));
    end

    $display("Covered %0d prefixed symbols at the smallest FFT size with long, short and %s",
             n_symbols, "extended prefixes, a mid-load settings change and a long stall.");
    $display("%0d samples stored, %0d emitted, %0d pushes refused, %0d empty pulls; %0d %s",
             n_stored, n_emitted, n_refused, n_idle_pulls, n_checked,
             $sformatf("result beats checked with %0d mismatches.", n_errors));
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
